/* sv/comb_sort_engine_top_defines.svh */
// Assertion macros shared by the comb sort engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef COMB_SORT_ENGINE_TOP_DEFINES_SVH
`define COMB_SORT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define CSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cse_pkg.sv */
// Shared types and constants of the comb sort engine.
// Used by cse_ctrl, cse_datapath and comb_sort_engine_top; no dependencies.
package cse_pkg;

    // gap * 10 / 13 computed as (gap * 50420) >> 16, exact for gap up to 64
    localparam logic [15:0] SHRINK_MUL   = 16'd50420;
    localparam int          SHRINK_SHIFT = 16;

    typedef struct packed {
        logic load_wr;    // store incoming word at count
        logic sort_init;  // gap = n, swap flag set
        logic pass_init;  // shrink gap, clear swap flag, index to zero
        logic rd_pair;    // read entries idx and idx + gap
        logic cmp_wr;     // write upper entry into lower slot, mark swap
        logic swap_wr;    // write lower entry into upper slot
        logic idx_inc;    // advance index
        logic out_init;   // index to zero for output burst
        logic out_rd;     // read entry idx for output
        logic out_done;   // burst finished, clear count and index
    } cse_cmd_t;

    typedef struct packed {
        logic close;      // incoming word ends the set
        logic more_pass;  // gap above one or a swap seen
        logic pair_ok;    // idx + gap inside the set
        logic greater;    // lower entry greater than upper entry
        logic out_last;   // idx points at the final entry
    } cse_stat_t;

endpackage

/* sv/comb_sort_engine_top.sv */
// Comb sort engine: collects a set of signed words, sorts ascending, emits a burst.
// Instantiates cse_ctrl and cse_datapath; depends on cse_pkg.
//
// Input channel s_*: one word per accepted beat; s_tready stays high while loading.
// s_tlast closes the set; a set also closes when MAX_ITEMS words are held.
// s_tready is low from the closing word until the sorted burst has gone out.
// Sorting: comb sort, gap shrinking by 10/13 (minimum 1) each pass, until a
// gap-one pass sees no swap. Each compare reads its pair (S_READ) from the
// two-read-port store, compares (S_CMP) and, if swapped, writes back (S_SWAP);
// each pass adds a gap update and the final out-of-range index check.
// Output channel m_*: one word per sorted element, m_tlast on the final one.
// Each output word is read from the store (S_ORD), then held in the output
// register (S_OUT); a low m_tready holds tdata and tlast until the word is taken.
// Reset clears count, gap, swap flag and sequencer; the store needs no clearing.
module comb_sort_engine_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // sorted_value
    output logic                                 m_tlast
);
    import cse_pkg::*;

    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;

    cse_cmd_t              cmd;
    cse_stat_t             stat;
    logic [DATA_WIDTH-1:0] out_value;

    cse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cse_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_value  (s_tdata[DATA_WIDTH-1:0]),
        .in_last   (s_tlast),
        .out_value (out_value)
    );

    assign m_tdata = TDW'(out_value);
    assign m_tlast = stat.out_last;

endmodule

/* sv/cse_ctrl.sv */
// Sequencer of the comb sort engine: load, sort passes and output burst.
// Depends on cse_pkg for the command and status structs.
module cse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output cse_pkg::cse_cmd_t cmd,
    input  cse_pkg::cse_stat_t stat
);
    import cse_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_PASS = 7'b0000010,
        S_READ = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_SWAP = 7'b0010000,
        S_ORD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_wr = 1'b1;
                    if (stat.close)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (stat.more_pass)
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_ORD;
                end
            end
            S_READ:
            begin
                if (stat.pair_ok)
                begin
                    cmd.rd_pair = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_PASS;
                end
            end
            S_CMP:
            begin
                if (stat.greater)
                begin
                    cmd.cmp_wr = 1'b1;
                    state_next = S_SWAP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_SWAP:
            begin
                cmd.swap_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_READ;
            end
            S_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (stat.out_last)
                    begin
                        cmd.out_done = 1'b1;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

/* sv/cse_datapath.sv */
// Element store, index, gap and swap registers of the comb sort engine.
// Depends on cse_pkg and comb_sort_engine_top_defines.svh.
`include "comb_sort_engine_top_defines.svh"

module cse_datapath #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cse_pkg::cse_cmd_t      cmd,
    output cse_pkg::cse_stat_t     stat,
    input  logic [DATA_WIDTH-1:0]  in_value,
    input  logic                   in_last,
    output logic [DATA_WIDTH-1:0]  out_value
);
    import cse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;
    localparam int PW = CW + SHRINK_SHIFT;

    logic [DATA_WIDTH-1:0] mem [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] rda_reg;
    logic [DATA_WIDTH-1:0] rdb_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic          swap_reg, swap_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic [PW-1:0] prod;
    logic [CW-1:0] shrunk;
    logic [CW-1:0] gap_new;
    logic [AW-1:0] addr_b;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    assign prod    = PW'(gap_reg) * PW'(SHRINK_MUL);
    assign shrunk  = prod[SHRINK_SHIFT +: CW];
    assign gap_new = (shrunk == '0) ? CW'(1) : shrunk;
    assign addr_b  = idx_reg + gap_reg[AW-1:0];

    assign stat.close     = in_last || (count_reg == CW'(MAX_ITEMS - 1));
    assign stat.more_pass = (gap_reg > CW'(1)) || swap_reg;
    assign stat.pair_ok   = (SW'(idx_reg) + SW'(gap_reg)) < SW'(count_reg);
    assign stat.greater   = $signed(rda_reg) > $signed(rdb_reg);
    assign stat.out_last  = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign out_value = rda_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rdb_reg;
        if (cmd.load_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = in_value;
        end
        else if (cmd.cmp_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = rdb_reg;
        end
        else if (cmd.swap_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_b;
            wr_data = rda_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pair || cmd.out_rd)
        begin
            rda_reg <= mem[idx_reg];
            rdb_reg <= mem[addr_b];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        gap_next   = gap_reg;
        swap_next  = swap_reg;
        idx_next   = idx_reg;
        if (cmd.load_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.sort_init)
        begin
            gap_next  = count_reg + CW'(1);
            swap_next = 1'b1;
        end
        if (cmd.pass_init)
        begin
            gap_next  = gap_new;
            swap_next = 1'b0;
            idx_next  = '0;
        end
        if (cmd.cmp_wr)
        begin
            swap_next = 1'b1;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.out_init)
        begin
            idx_next = '0;
        end
        if (cmd.out_done)
        begin
            count_next = '0;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            gap_reg   <= '0;
            swap_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            gap_reg   <= gap_next;
            swap_reg  <= swap_next;
            idx_reg   <= idx_next;
        end
    end

    `CSE_ASSERT_NEXT(a_swap_follows_cmp, clk, rst_n, cmd.cmp_wr, cmd.swap_wr, "swap write missing after compare write")
    `CSE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ITEMS), "element count beyond store depth")
    `CSE_ASSERT_NEXT(a_gap_nonzero, clk, rst_n, cmd.pass_init, gap_reg != '0, "gap shrank to zero")
    `CSE_ASSERT_NOW(a_pair_in_set, clk, rst_n, cmd.rd_pair, stat.pair_ok, "pair read outside the set")

endmodule

/* tb/comb_sort_engine_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for comb_sort_engine_top: sets of signed words in,
// ascending bursts out, checked word by word against an in-bench comb sort or a row's listed value.
// Needs only the RTL of comb_sort_engine_top, its sub-modules, cse_pkg and the defines header.
module comb_sort_engine_top_tb;

    localparam int          MAX_ITEMS      = 64;
    localparam int          DATA_WIDTH     = 32;
    localparam int          RANDOM_WORDS   = 250;
    localparam int          HOLD_CYCLES    = 500;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int          WATCHDOG_LIMIT = 60000;
    localparam logic [31:0] WORD_MAX       = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN       = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sorted_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [31:0] typed_value;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // value
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // sorted_value
    logic        m_tlast;

    logic signed [31:0] set_words [MAX_ITEMS];
    int                 set_fill = 0;
    sorted_word_t       sorted_due [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    stim_row_t directed_rows [21] = '{
        '{WORD_MAX,     1'b1, 1'b1, WORD_MAX},
        '{WORD_MIN,     1'b1, 1'b1, WORD_MIN},
        '{32'h0,        1'b1, 1'b1, 32'h0},
        '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
        '{WORD_MAX,     1'b0, 1'b0, 32'h0},
        '{WORD_MIN,     1'b1, 1'b0, 32'h0},
        '{32'd5,        1'b0, 1'b0, 32'h0},
        '{32'd5,        1'b0, 1'b0, 32'h0},
        '{32'd5,        1'b1, 1'b0, 32'h0},
        '{32'h0,        1'b0, 1'b0, 32'h0},
        '{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
        '{32'd1,        1'b0, 1'b0, 32'h0},
        '{WORD_MIN,     1'b0, 1'b0, 32'h0},
        '{WORD_MAX,     1'b0, 1'b0, 32'h0},
        '{WORD_MIN,     1'b1, 1'b0, 32'h0},
        '{32'd30,       1'b0, 1'b0, 32'h0},
        '{32'd20,       1'b0, 1'b0, 32'h0},
        '{32'd10,       1'b0, 1'b0, 32'h0},
        '{32'd0,        1'b0, 1'b0, 32'h0},
        '{-32'sd10,     1'b0, 1'b0, 32'h0},
        '{-32'sd20,     1'b1, 1'b0, 32'h0}
    };

    comb_sort_engine_top #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // store one word; on a closing word comb-sort the set and return its size
    function automatic int absorb_word(input logic [31:0] value, input logic last);
        int                 n;
        int                 gap;
        bit                 swapped;
        logic signed [31:0] hold;
        if (set_fill >= MAX_ITEMS)
            set_fill = 0;
        set_words[set_fill] = value;
        set_fill++;
        if (!last && set_fill < MAX_ITEMS)
            return 0;
        n       = set_fill;
        gap     = n;
        swapped = 1'b1;
        while (gap > 1 || swapped)
        begin
            gap = (gap * 10) / 13;
            if (gap < 1)
                gap = 1;
            swapped = 1'b0;
            for (int i = 0; i + gap < n; i++)
            begin
                if (set_words[i] > set_words[i + gap])
                begin
                    hold               = set_words[i];
                    set_words[i]       = set_words[i + gap];
                    set_words[i + gap] = hold;
                    swapped            = 1'b1;
                end
            end
        end
        set_fill = 0;
        return n;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return 32'($urandom_range(0, 7)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_word(input logic [31:0] value, input logic last, input int pause,
                              input logic typed, input logic [31:0] typed_value);
        int n;
        if (pause > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        n = absorb_word(value, last);
        if (n > 0 && typed)
            sorted_due.push_back('{typed_value, 1'b1});
        else
            for (int k = 0; k < n; k++)
                sorted_due.push_back('{set_words[k], (k == n - 1)});
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int           pause;
        int           taken;
        bit           brisk;
        logic [31:0]  got_value;
        logic         got_last;
        sorted_word_t due;
        taken = 0;
        brisk = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 16 == 0)
                brisk = ($urandom_range(0, 2) == 0);
            pause = brisk ? 0 : $urandom_range(0, 17);
            if (taken == 25)
                pause = HOLD_CYCLES;
            if (pause > 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid) @(negedge clk);
            got_value = m_tdata;
            got_last  = m_tlast;
            @(posedge clk);
            taken++;
            if (sorted_due.size() == 0)
                note_mismatch("unexpected word", got_value, 32'h0);
            else
            begin
                due = sorted_due.pop_front();
                if (got_value !== due.value)
                    note_mismatch("sorted_value", got_value, due.value);
                if (got_last !== due.last)
                    note_mismatch("sorted_last", 32'(got_last), 32'(due.last));
            end
        end
    end

    initial
    begin
        int   words_sent;
        int   set_no;
        int   size;
        bit   brisk;
        logic last;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            offer_word(directed_rows[r].value, directed_rows[r].last, $urandom_range(0, 17),
                       directed_rows[r].typed, directed_rows[r].typed_value);

        // the first two sets fill the store, closing without and with tlast
        words_sent = 0;
        set_no     = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (set_no < 2 || $urandom_range(0, 19) == 0)
                size = MAX_ITEMS;
            else
                size = $urandom_range(1, 12);
            brisk = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < size; k++)
            begin
                if (k < size - 1)
                    last = 1'b0;
                else if (size < MAX_ITEMS)
                    last = 1'b1;
                else if (set_no == 0)
                    last = 1'b0;
                else if (set_no == 1)
                    last = 1'b1;
                else
                    last = $urandom_range(0, 1);
                offer_word(pick_value(), last, brisk ? 0 : $urandom_range(0, 17), 1'b0, 32'h0);
            end
            words_sent += size;
            set_no++;
        end
        s_tvalid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
